[rtl/ckcb_pkg.sv]
`default_nettype none
package ckcb_pkg;

  localparam int MAX_DIM = 4096;
  localparam int COL_W   = $clog2(MAX_DIM);      // source column counter
  localparam int SW_W    = $clog2(MAX_DIM + 1);  // clamped source width
  localparam int DIM_W   = 13;                   // screen and blit sizes
  localparam int POS_W   = 12;                   // destination origin
  localparam int ROW_W   = 13;
  localparam int IDX_W   = 24;
  localparam int KEY_W   = 25;
  localparam logic [ROW_W-1:0] ROW_MAX = '1;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_DEST_X        = 3'd2,
    REG_DEST_Y        = 3'd3,
    REG_BLIT_WIDTH    = 3'd4,
    REG_BLIT_HEIGHT   = 3'd5,
    REG_SOURCE_WIDTH  = 3'd6,
    REG_COLOR_KEY     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
  } fb_wr_t;

  // blit geometry settled from the registers
  typedef struct packed {
    logic             on_screen;
    logic [SW_W-1:0]  clip_w;
    logic [DIM_W-1:0] clip_h;
    logic [SW_W-1:0]  eff_sw;
    logic [POS_W-1:0] dest_x;
    logic [DIM_W-1:0] screen_width;
    logic [IDX_W-1:0] row_base0;
    logic             key_en;
    logic [23:0]      key;
  } geom_t;

endpackage
`default_nettype wire

[rtl/ckcb_cfg.sv]
`default_nettype none
module ckcb_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [ckcb_pkg::KEY_W-1:0]  cfg_data,
  output ckcb_pkg::geom_t                  geom
);

  logic [ckcb_pkg::DIM_W-1:0] screen_width;
  logic [ckcb_pkg::DIM_W-1:0] screen_height;
  logic [ckcb_pkg::POS_W-1:0] dest_x;
  logic [ckcb_pkg::POS_W-1:0] dest_y;
  logic [ckcb_pkg::DIM_W-1:0] blit_width;
  logic [ckcb_pkg::DIM_W-1:0] blit_height;
  logic [ckcb_pkg::DIM_W-1:0] source_width;
  logic [ckcb_pkg::KEY_W-1:0] color_key;

  ckcb_pkg::geom_t             geom_next;
  logic [ckcb_pkg::SW_W-1:0]  eff_sw;
  logic [ckcb_pkg::SW_W-1:0]  w0;
  logic [ckcb_pkg::DIM_W:0]   x_end;
  logic [ckcb_pkg::DIM_W:0]   y_end;
  logic [ckcb_pkg::DIM_W:0]   x_room;
  logic [ckcb_pkg::DIM_W:0]   y_room;
  logic [ckcb_pkg::DIM_W+ckcb_pkg::POS_W-1:0] base_prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ckcb_pkg::DIM_W'(800);
      screen_height <= ckcb_pkg::DIM_W'(600);
      dest_x        <= '0;
      dest_y        <= '0;
      blit_width    <= '0;
      blit_height   <= '0;
      source_width  <= ckcb_pkg::DIM_W'(1);
      color_key     <= '0;
    end else if (cfg_valid) begin
      case (ckcb_pkg::cfg_reg_t'(cfg_index))
        ckcb_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[ckcb_pkg::DIM_W-1:0];
        ckcb_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[ckcb_pkg::DIM_W-1:0];
        ckcb_pkg::REG_DEST_X:        dest_x        <= cfg_data[ckcb_pkg::POS_W-1:0];
        ckcb_pkg::REG_DEST_Y:        dest_y        <= cfg_data[ckcb_pkg::POS_W-1:0];
        ckcb_pkg::REG_BLIT_WIDTH:    blit_width    <= cfg_data[ckcb_pkg::DIM_W-1:0];
        ckcb_pkg::REG_BLIT_HEIGHT:   blit_height   <= cfg_data[ckcb_pkg::DIM_W-1:0];
        ckcb_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[ckcb_pkg::DIM_W-1:0];
        ckcb_pkg::REG_COLOR_KEY:     color_key     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // zero width reads as one, oversize as the maximum
    if (source_width == '0) begin
      eff_sw = ckcb_pkg::SW_W'(1);
    end else if (int'(source_width) > ckcb_pkg::MAX_DIM) begin
      eff_sw = ckcb_pkg::SW_W'(ckcb_pkg::MAX_DIM);
    end else begin
      eff_sw = ckcb_pkg::SW_W'(source_width);
    end

    if ((ckcb_pkg::DIM_W+1)'(blit_width) < (ckcb_pkg::DIM_W+1)'(eff_sw)) begin
      w0 = ckcb_pkg::SW_W'(blit_width);
    end else begin
      w0 = eff_sw;
    end

    x_end  = (ckcb_pkg::DIM_W+1)'(dest_x) + (ckcb_pkg::DIM_W+1)'(w0);
    y_end  = (ckcb_pkg::DIM_W+1)'(dest_y) + (ckcb_pkg::DIM_W+1)'(blit_height);
    x_room = (ckcb_pkg::DIM_W+1)'(screen_width) - (ckcb_pkg::DIM_W+1)'(dest_x);
    y_room = (ckcb_pkg::DIM_W+1)'(screen_height) - (ckcb_pkg::DIM_W+1)'(dest_y);

    geom_next.on_screen = ((ckcb_pkg::DIM_W)'(dest_x) < screen_width) &&
                          ((ckcb_pkg::DIM_W)'(dest_y) < screen_height);
    geom_next.clip_w = (x_end > (ckcb_pkg::DIM_W+1)'(screen_width)) ?
                       ckcb_pkg::SW_W'(x_room) : w0;
    geom_next.clip_h = (y_end > (ckcb_pkg::DIM_W+1)'(screen_height)) ?
                       ckcb_pkg::DIM_W'(y_room) : blit_height;
    geom_next.eff_sw       = eff_sw;
    geom_next.dest_x       = dest_x;
    geom_next.screen_width = screen_width;
    base_prod              = dest_y * screen_width;
    geom_next.row_base0    = base_prod[ckcb_pkg::IDX_W-1:0];
    geom_next.key_en       = color_key[24];
    geom_next.key          = color_key[23:0];
  end

  // registered copy; pixels are not held off while it settles after a write
  always_ff @(posedge clk) begin
    geom <= geom_next;
  end

endmodule
`default_nettype wire

[rtl/color_keyed_clipped_blit_unit.sv]
`default_nettype none
// channel | direction | handshake           | payload
// pix     | in        | pix_valid/pix_ready | ckcb_pkg::pix_t, one source pixel
// fb      | out       | fb_valid/fb_ready   | ckcb_pkg::fb_wr_t, one framebuffer write
// cfg     | in        | cfg_valid/cfg_ready | cfg_index (3 bits), cfg_data (25 bits)
//
// one source pixel per cycle unless a write waits on fb_ready low; a pixel passes
// through the input register and then the result register
// rst is synchronous and clears counters, valids and config registers to defaults
// fb_ready low stalls only a pixel that produces a write; clipped or keyed
// pixels drain past a waiting result
module color_keyed_clipped_blit_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        pix_valid,
  output logic                             pix_ready,
  input  wire ckcb_pkg::pix_t              pix,
  output logic                             fb_valid,
  input  wire logic                        fb_ready,
  output ckcb_pkg::fb_wr_t                 fb,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [ckcb_pkg::KEY_W-1:0]  cfg_data
);

  ckcb_pkg::geom_t             geom;
  logic                        s1_valid;
  ckcb_pkg::pix_t              s1;
  logic                        s1_go;
  logic                        hit;

  logic [ckcb_pkg::COL_W-1:0]  source_column;
  logic [ckcb_pkg::ROW_W-1:0]  source_row;
  logic [ckcb_pkg::IDX_W-1:0]  row_base_index;
  logic [ckcb_pkg::COL_W-1:0]  source_column_next;
  logic [ckcb_pkg::ROW_W-1:0]  source_row_next;
  logic [ckcb_pkg::IDX_W-1:0]  row_base_index_next;

  logic [ckcb_pkg::COL_W-1:0]  col;
  logic [ckcb_pkg::ROW_W-1:0]  row;
  logic [ckcb_pkg::IDX_W-1:0]  base;
  logic [ckcb_pkg::SW_W-1:0]   col_inc;
  logic [ckcb_pkg::IDX_W-1:0]  index;

  ckcb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  always_comb begin
    // a frame start restarts the counters for this very pixel
    col  = s1.frame_start ? '0 : source_column;
    row  = s1.frame_start ? '0 : source_row;
    base = s1.frame_start ? geom.row_base0 : row_base_index;

    hit = geom.on_screen &&
          (ckcb_pkg::SW_W'(col) < geom.clip_w) &&
          (row < geom.clip_h) &&
          !(geom.key_en && ({s1.red, s1.green, s1.blue} == geom.key));

    index = base + ckcb_pkg::IDX_W'(geom.dest_x) + ckcb_pkg::IDX_W'(col);

    s1_go     = s1_valid && (!hit || !fb_valid || fb_ready);
    pix_ready = !s1_valid || s1_go;

    col_inc = ckcb_pkg::SW_W'(col) + ckcb_pkg::SW_W'(1);
    source_column_next  = ckcb_pkg::COL_W'(col_inc);
    source_row_next     = row;
    row_base_index_next = base;
    if (col_inc >= geom.eff_sw) begin
      source_column_next = '0;
      if (row < ckcb_pkg::ROW_MAX) begin
        source_row_next     = row + ckcb_pkg::ROW_W'(1);
        row_base_index_next = base + ckcb_pkg::IDX_W'(geom.screen_width);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      source_column  <= '0;
      source_row     <= '0;
      row_base_index <= '0;
      fb_valid       <= 1'b0;
    end else begin
      if (pix_ready) begin
        s1_valid <= pix_valid;
      end
      if (s1_go) begin
        source_column  <= source_column_next;
        source_row     <= source_row_next;
        row_base_index <= row_base_index_next;
      end
      if (s1_go && hit) begin
        fb_valid <= 1'b1;
      end else if (fb_ready) begin
        fb_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      s1 <= pix;
    end
    if (s1_go && hit) begin
      fb.pixel_index <= index;
      fb.out_red     <= s1.red;
      fb.out_green   <= s1.green;
      fb.out_blue    <= s1.blue;
    end
  end

endmodule
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;

  localparam int PERIOD        = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int CALM_FROM     = 1600;
  localparam int MAX_IMAGE     = 150;
  localparam int SHOW_LIMIT    = 50;
  localparam int KEY_EN_BIT    = 24;
  localparam int unsigned KEY_ENABLE = 32'h1 << KEY_EN_BIT;
  localparam int unsigned DIM_TOP    = (1 << ckcb_pkg::DIM_W) - 1;
  localparam int unsigned POS_TOP    = (1 << ckcb_pkg::POS_W) - 1;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       pix_valid = 1'b0;
  logic                       pix_ready;
  ckcb_pkg::pix_t             pix       = '0;
  logic                       fb_valid;
  logic                       fb_ready  = 1'b0;
  ckcb_pkg::fb_wr_t           fb;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [2:0]                 cfg_index = ckcb_pkg::REG_SCREEN_WIDTH;
  logic [ckcb_pkg::KEY_W-1:0] cfg_data  = '0;

  color_keyed_clipped_blit_unit dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .fb_valid  (fb_valid),
    .fb_ready  (fb_ready),
    .fb        (fb),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // shadow registers and blit counters
  logic [ckcb_pkg::DIM_W-1:0] scr_w, scr_h, req_w, req_h, src_w;
  logic [ckcb_pkg::POS_W-1:0] org_x, org_y;
  logic [ckcb_pkg::KEY_W-1:0] key_reg;
  logic [ckcb_pkg::COL_W-1:0] col_cnt;
  logic [ckcb_pkg::ROW_W-1:0] row_cnt;
  logic [ckcb_pkg::IDX_W-1:0] row_base;

  ckcb_pkg::pix_t   source_pixels [$];
  ckcb_pkg::fb_wr_t fb_writes_due [$];
  int unsigned plan [8];
  bit          idle_on = 1'b0;
  int          pix_gap = 0;
  int          fb_gap  = 0;
  int          quiet   = 0;
  int          pixels_queued   = 0;
  int          pixels_sent     = 0;
  int          writes_checked  = 0;
  int          settings_used   = 0;
  int          mismatches      = 0;

  function automatic void load_shadow(ckcb_pkg::cfg_reg_t r, logic [ckcb_pkg::KEY_W-1:0] v);
    case (r)
      ckcb_pkg::REG_SCREEN_WIDTH:  scr_w = v[ckcb_pkg::DIM_W-1:0];
      ckcb_pkg::REG_SCREEN_HEIGHT: scr_h = v[ckcb_pkg::DIM_W-1:0];
      ckcb_pkg::REG_DEST_X:        org_x = v[ckcb_pkg::POS_W-1:0];
      ckcb_pkg::REG_DEST_Y:        org_y = v[ckcb_pkg::POS_W-1:0];
      ckcb_pkg::REG_BLIT_WIDTH:    req_w = v[ckcb_pkg::DIM_W-1:0];
      ckcb_pkg::REG_BLIT_HEIGHT:   req_h = v[ckcb_pkg::DIM_W-1:0];
      ckcb_pkg::REG_SOURCE_WIDTH:  src_w = v[ckcb_pkg::DIM_W-1:0];
      ckcb_pkg::REG_COLOR_KEY:     key_reg = v;
      default: ;
    endcase
  endfunction

  // one source pixel: returns 1 with the framebuffer write it should cause
  function automatic bit blit_pixel(input ckcb_pkg::pix_t p, output ckcb_pkg::fb_wr_t wr);
    int unsigned eff_w, clip_w, clip_h;
    bit hit;
    hit = 1'b0;
    wr = '0;
    eff_w = (src_w == 0) ? 1 : (src_w > ckcb_pkg::MAX_DIM) ? ckcb_pkg::MAX_DIM : src_w;
    if (p.frame_start) begin
      col_cnt = '0;
      row_cnt = '0;
      row_base = ckcb_pkg::IDX_W'(int'(org_y) * int'(scr_w));
    end
    if (org_x < scr_w && org_y < scr_h) begin
      clip_w = (req_w < eff_w) ? req_w : eff_w;
      if (org_x + clip_w > scr_w) clip_w = scr_w - org_x;
      clip_h = req_h;
      if (org_y + clip_h > scr_h) clip_h = scr_h - org_y;
      if (col_cnt < clip_w && row_cnt < clip_h &&
          !(key_reg[KEY_EN_BIT] && {p.red, p.green, p.blue} == key_reg[23:0])) begin
        hit = 1'b1;
        wr.pixel_index = ckcb_pkg::IDX_W'(row_base + org_x + col_cnt);
        wr.out_red     = p.red;
        wr.out_green   = p.green;
        wr.out_blue    = p.blue;
      end
    end
    if (col_cnt + 1 >= eff_w) begin
      col_cnt = '0;
      // row count saturates, and the row base stops with it
      if (row_cnt < ckcb_pkg::ROW_MAX) begin
        row_cnt = row_cnt + 1'b1;
        row_base = ckcb_pkg::IDX_W'(row_base + scr_w);
      end
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return hit;
  endfunction

  function automatic void check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
    end
  endfunction

  // source pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      pix_gap = 0;
    end else if (!pix_valid || pix_ready) begin
      if (pix_gap > 0) begin
        pix_gap--;
        pix_valid <= 1'b0;
      end else if (source_pixels.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
        pix_gap = $urandom_range(0, 3);
        pix_valid <= 1'b0;
      end else if (source_pixels.size() != 0) begin
        pix <= source_pixels.pop_front();
        pix_valid <= 1'b1;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // framebuffer side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      fb_ready <= 1'b0;
      fb_gap = 0;
    end else if (fb_gap > 0) begin
      fb_gap--;
      fb_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      fb_gap = $urandom_range(0, 3);
      fb_ready <= 1'b0;
    end else begin
      fb_ready <= 1'b1;
    end
  end

  // monitor: predict on each accepted pixel, then check each accepted write
  always @(posedge clk) begin : monitor
    ckcb_pkg::fb_wr_t want;
    if (rst) begin
      scr_w = 13'd800;
      scr_h = 13'd600;
      org_x = '0;
      org_y = '0;
      req_w = '0;
      req_h = '0;
      src_w = 13'd1;
      key_reg = '0;
      col_cnt = '0;
      row_cnt = '0;
      row_base = '0;
    end else begin
      if (cfg_valid && cfg_ready) load_shadow(ckcb_pkg::cfg_reg_t'(cfg_index), cfg_data);
      if (pix_valid && pix_ready) begin
        pixels_sent++;
        if (blit_pixel(pix, want)) fb_writes_due.push_back(want);
      end
      if (fb_valid && fb_ready) begin
        if (fb_writes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: write with nothing expected, got %0h", $time, fb);
        end else begin
          want = fb_writes_due.pop_front();
          check_field("pixel_index", want.pixel_index, fb.pixel_index);
          check_field("out_red", want.out_red, fb.out_red);
          check_field("out_green", want.out_green, fb.out_green);
          check_field("out_blue", want.out_blue, fb.out_blue);
          writes_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && pix_ready) || (fb_valid && fb_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("** color_keyed_clipped_blit_unit: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_regs();
    ckcb_pkg::cfg_reg_t r;
    r = r.first();
    repeat (r.num()) begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= ckcb_pkg::KEY_W'(plan[r]);
      do @(posedge clk); while (cfg_ready !== 1'b1);
      r = r.next();
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic load_regs(input int unsigned sw, sh, dx, dy, bw, bh, srcw, key);
    plan[ckcb_pkg::REG_SCREEN_WIDTH]  = sw;
    plan[ckcb_pkg::REG_SCREEN_HEIGHT] = sh;
    plan[ckcb_pkg::REG_DEST_X]        = dx;
    plan[ckcb_pkg::REG_DEST_Y]        = dy;
    plan[ckcb_pkg::REG_BLIT_WIDTH]    = bw;
    plan[ckcb_pkg::REG_BLIT_HEIGHT]   = bh;
    plan[ckcb_pkg::REG_SOURCE_WIDTH]  = srcw;
    plan[ckcb_pkg::REG_COLOR_KEY]     = key;
    write_regs();
  endtask

  // wait for the pipe to empty; keyed or clipped pixels leave no write behind
  task automatic settle();
    while (source_pixels.size() != 0 || pix_valid || fb_writes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_pixel(input bit start, input logic [23:0] rgb);
    ckcb_pkg::pix_t p;
    p.frame_start = start;
    p.red   = rgb[23:16];
    p.green = rgb[15:8];
    p.blue  = rgb[7:0];
    source_pixels.push_back(p);
    pixels_queued++;
  endtask

  // colours biased towards the key and its near misses
  function automatic logic [23:0] pick_colour();
    logic [23:0] k;
    k = 24'(plan[ckcb_pkg::REG_COLOR_KEY]);
    case ($urandom_range(0, 4))
      0: return k;
      1: return k ^ (24'd1 << $urandom_range(0, 23));
      2: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic bit rare();
    return $urandom_range(0, 9) == 0;
  endfunction

  function automatic int unsigned odd_size();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return ckcb_pkg::MAX_DIM;
      2: return ckcb_pkg::MAX_DIM + 1;
      3: return DIM_TOP;
      default: return $urandom_range(0, DIM_TOP);
    endcase
  endfunction

  function automatic int unsigned odd_pos();
    return $urandom_range(0, 1) ? POS_TOP : $urandom_range(0, POS_TOP);
  endfunction

  initial begin : stimulus
    int rand_from, images, rows, n, eff;
    bit start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values give a zero-sized blit
    add_pixel(1'b1, 24'hFFFFFF);
    add_pixel(1'b0, 24'h000000);
    settle();

    // everything at the top of its field: wide source clamped, index wraps, keyed white
    load_regs(DIM_TOP, DIM_TOP, POS_TOP, POS_TOP, DIM_TOP, DIM_TOP, DIM_TOP,
              KEY_ENABLE | 32'hFFFFFF);
    add_pixel(1'b1, 24'hFFFFFF);
    add_pixel(1'b0, 24'h000000);
    add_pixel(1'b0, 24'hFFFFFE);
    add_pixel(1'b0, 24'h00FF00);
    settle();

    // source width zero acts as one; height clipped; key colour with keying off
    load_regs(4, 3, 1, 1, 5, 5, 0, 32'h123456);
    add_pixel(1'b1, 24'h123456);
    add_pixel(1'b0, 24'h123456);
    add_pixel(1'b0, 24'hFF0000);
    add_pixel(1'b0, 24'h0000FF);
    settle();

    // origin just off the right edge, then just off the bottom
    load_regs(16, 16, 16, 0, 4, 4, 4, 0);
    add_pixel(1'b1, 24'hABCDEF);
    add_pixel(1'b0, 24'h010203);
    add_pixel(1'b0, 24'hFFFFFF);
    settle();
    load_regs(16, 16, 0, 16, 4, 4, 4, 0);
    add_pixel(1'b1, 24'h5A5A5A);
    add_pixel(1'b0, 24'hA5A5A5);
    settle();

    // zero-sized screen
    load_regs(0, 0, 0, 0, 4, 4, 4, 0);
    add_pixel(1'b1, 24'h808080);
    add_pixel(1'b0, 24'h7F7F7F);
    settle();

    // stride change mid-image applies from the next row; a new dest_y only from the next frame start
    load_regs(10, 10, 0, 2, 4, 4, 2, 0);
    add_pixel(1'b1, 24'h111111);
    add_pixel(1'b0, 24'h222222);
    add_pixel(1'b0, 24'h333333);
    settle();
    load_regs(20, 10, 0, 1, 4, 4, 2, 0);
    add_pixel(1'b0, 24'h444444);
    add_pixel(1'b0, 24'h555555);
    add_pixel(1'b0, 24'h666666);
    add_pixel(1'b1, 24'h777777);
    add_pixel(1'b0, 24'h888888);
    settle();

    rand_from = pixels_queued;
    while (pixels_queued - rand_from < RANDOM_ITEMS) begin
      idle_on = (pixels_queued - rand_from < CALM_FROM) && ($urandom_range(0, 3) != 0);
      load_regs(rare() ? odd_size() : $urandom_range(1, 40),
                rare() ? odd_size() : $urandom_range(1, 40),
                rare() ? odd_pos() : $urandom_range(0, 44),
                rare() ? odd_pos() : $urandom_range(0, 44),
                rare() ? odd_size() : $urandom_range(0, 48),
                rare() ? odd_size() : $urandom_range(0, 48),
                rare() ? odd_size() : $urandom_range(1, 24),
                $urandom_range(0, 1) ? (KEY_ENABLE | ($urandom & 32'hFFFFFF))
                                     : ($urandom & 32'hFFFFFF));
      eff = plan[ckcb_pkg::REG_SOURCE_WIDTH];
      eff = (eff == 0) ? 1 : (eff > ckcb_pkg::MAX_DIM) ? ckcb_pkg::MAX_DIM : eff;
      images = $urandom_range(1, 3);
      repeat (images) begin
        rows = $urandom_range(1, 6);
        n = (eff * rows > MAX_IMAGE) ? MAX_IMAGE : eff * rows;
        // mostly whole images; now and then a carried-on image or a stray frame start
        start = $urandom_range(0, 9) != 0;
        for (int i = 0; i < n; i++)
          add_pixel((i == 0) ? start : ($urandom_range(0, 49) == 0), pick_colour());
      end
      settle();
    end

    $display("sent %0d source pixels over %0d register settings", pixels_sent, settings_used);
    $display("checked %0d framebuffer writes, %0d mismatches", writes_checked, mismatches);
    if (mismatches == 0)
      $display("** color_keyed_clipped_blit_unit: PASSED **");
    else
      $display("** color_keyed_clipped_blit_unit: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
rtl/ckcb_pkg.sv
rtl/ckcb_cfg.sv
rtl/color_keyed_clipped_blit_unit.sv
verif/tb.sv
